/* rtl/fpdf_pkg.sv */
// Shared types and character constants for the fixed-point decimal formatter.
// No dependencies; imported by fixed_point_decimal_formatter_core.
package fpdf_pkg;

    localparam int VALUE_W   = 64;
    localparam int NUM_DIGITS = 20;          // BCD digits of a 64-bit magnitude
    localparam int SCALE_DIGITS = 8;         // scale is ten to the eighth
    localparam int IN_TDATA_W = 80;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = 8;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_ROUND,
        ST_SCAN,
        ST_SIGN,
        ST_DOLLAR,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_NUL
    } fmt_state_t;

    typedef logic [3:0] bcd_digit_t;

endpackage

/* rtl/fixed_point_decimal_formatter_core.sv */
// Fixed-point to decimal ASCII formatter: shift-add-3 converter, serial
// rounding adder and character sequencer. Depends on fpdf_pkg.
//
// Usage:
//   Slave channel (s_*): one beat carries a signed 64-bit value scaled by
//   ten to the eighth, a fraction digit count, a room limit and two flags.
//   Master channel (m_*): one character per beat, m_tdata[7:0]; the text is
//   closed by a NUL beat with m_tlast high.
//   s_tready is high only while the core is idle. After a beat is taken the
//   core runs shift-add-3 conversion on the magnitude, serial decimal carry
//   for rounding, a scan that skips leading zeros, the sign and dollar
//   slots, then one character per cycle while m_tready allows, plus the NUL
//   beat. The next number is taken only once the core is back in idle; the
//   rounding carry runs through the single digit adder one digit at a time.
//   The output beat sits in a register; while m_tready is low the sequencer
//   holds and no character is lost. The core may accept the next number
//   while the final NUL still waits to be taken.
//   Reset (rst_n low, asynchronous) returns the core to idle with no output
//   beat pending.
module fixed_point_decimal_formatter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: [63:0] value, [67:64] decimals, [74:68] room, [79:75] zero
    input  logic [fpdf_pkg::IN_TDATA_W-1:0] s_tdata,
    // s_tuser: [0] grouped, [1] dollar
    input  logic [fpdf_pkg::IN_TUSER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: [7:0] ch
    output logic [fpdf_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import fpdf_pkg::*;

    fmt_state_t state_reg, state_next;

    logic [VALUE_W-1:0] mag_reg, mag_next;
    bcd_digit_t         bcd_reg [NUM_DIGITS];
    bcd_digit_t         bcd_next [NUM_DIGITS];
    logic [5:0]         cnt_reg, cnt_next;
    logic [4:0]         idx_reg, idx_next;
    logic               neg_reg, neg_next;
    logic               dol_reg, dol_next;
    logic               grp_reg, grp_next;
    logic [3:0]         dec_reg, dec_next;
    logic [6:0]         limit_reg, limit_next;
    logic [4:0]         sent_reg, sent_next;
    logic               first_reg, first_next;
    logic               comma_reg, comma_next;
    logic [1:0]         cnt3_reg, cnt3_next;
    logic [2:0]         add_reg, add_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_ch_reg, out_ch_next;
    logic               out_last_reg, out_last_next;

    logic               can_push, at_limit, want, push, need_comma;
    logic [7:0]         push_ch;
    bcd_digit_t         cur_digit;
    logic [4:0]         rsum;
    logic [4:0]         frac_end;
    logic [63:0]        in_value;
    logic [3:0]         in_dec;
    logic [6:0]         in_room;

    assign in_value = s_tdata[63:0];
    assign in_dec   = s_tdata[67:64];
    assign in_room  = s_tdata[74:68];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ch_reg;
    assign m_tlast  = out_last_reg;

    assign can_push   = !out_valid_reg || m_tready;
    assign at_limit   = ({2'b00, sent_reg} == limit_reg);
    assign cur_digit  = bcd_reg[idx_reg];
    assign rsum       = {1'b0, cur_digit} + {2'b00, add_reg};
    assign frac_end   = 5'(SCALE_DIGITS) - {1'b0, dec_reg};
    assign need_comma = grp_reg && !first_reg && (cnt3_reg == 2'd0) && !comma_reg;

    // integer digits left (this one included) modulo three, for idx 8..19
    function automatic logic [1:0] left_mod3(input logic [4:0] idx);
        logic [1:0] r;
        begin
            r = 2'd0;
            if (idx inside {5'd8, 5'd11, 5'd14, 5'd17})
                r = 2'd1;
            else if (idx inside {5'd9, 5'd12, 5'd15, 5'd18})
                r = 2'd2;
            return r;
        end
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (cnt_reg == 6'd63)
                    state_next = (dec_reg < 4'(SCALE_DIGITS)) ? ST_ROUND : ST_SCAN;
            end
            ST_ROUND:
            begin
                if (rsum < 5'd10 || idx_reg == 5'(NUM_DIGITS - 1))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == 5'(SCALE_DIGITS) || cur_digit != 4'd0)
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                if (!want)
                    state_next = ST_DOLLAR;
                else if (push)
                    state_next = at_limit ? ST_IDLE : ST_DOLLAR;
            end
            ST_DOLLAR:
            begin
                if (!want)
                    state_next = ST_INT;
                else if (push)
                    state_next = at_limit ? ST_IDLE : ST_INT;
            end
            ST_INT:
            begin
                if (push)
                begin
                    if (at_limit)
                        state_next = ST_IDLE;
                    else if (!need_comma && idx_reg == 5'(SCALE_DIGITS))
                        state_next = (dec_reg == 4'd0) ? ST_NUL : ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (push)
                    state_next = at_limit ? ST_IDLE : ST_FRAC;
            end
            ST_FRAC:
            begin
                if (push)
                begin
                    if (at_limit)
                        state_next = ST_IDLE;
                    else if (idx_reg == frac_end)
                        state_next = ST_NUL;
                end
            end
            ST_NUL:
            begin
                if (push)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // character to send in the current state
    always_comb
    begin
        want    = 1'b0;
        push_ch = CH_NUL;
        case (state_reg)
            ST_SIGN:
            begin
                want    = neg_reg;
                push_ch = CH_MINUS;
            end
            ST_DOLLAR:
            begin
                want    = dol_reg;
                push_ch = CH_DOLLAR;
            end
            ST_INT:
            begin
                want    = 1'b1;
                push_ch = need_comma ? CH_COMMA : (CH_ZERO | {4'd0, cur_digit});
            end
            ST_DOT:
            begin
                want    = 1'b1;
                push_ch = CH_DOT;
            end
            ST_FRAC:
            begin
                want    = 1'b1;
                push_ch = CH_ZERO | {4'd0, cur_digit};
            end
            ST_NUL:
            begin
                want    = 1'b1;
                push_ch = CH_NUL;
            end
            default:
            begin
                want    = 1'b0;
                push_ch = CH_NUL;
            end
        endcase
        if (at_limit || state_reg == ST_NUL)
            push_ch = CH_NUL;
        push = want && can_push;
    end

    // datapath
    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        dol_next   = dol_reg;
        grp_next   = grp_reg;
        dec_next   = dec_reg;
        limit_next = limit_reg;
        sent_next  = sent_reg;
        first_next = first_reg;
        comma_next = comma_reg;
        cnt3_next  = cnt3_reg;
        add_next   = add_reg;

        out_valid_next = out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_ch_next    = push_ch;
            out_last_next  = at_limit || state_reg == ST_NUL;
            sent_next      = sent_reg + 5'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next   = in_value[63];
                    mag_next   = in_value[63] ? (64'd0 - in_value) : in_value;
                    dec_next   = (in_dec > 4'(SCALE_DIGITS)) ? 4'(SCALE_DIGITS) : in_dec;
                    grp_next   = s_tuser[0];
                    dol_next   = s_tuser[1];
                    limit_next = (in_room == 7'd0) ? 7'd0 : in_room - 7'd1;
                    cnt_next   = 6'd0;
                    sent_next  = 5'd0;
                    for (int j = 0; j < NUM_DIGITS; j++)
                        bcd_next[j] = 4'd0;
                end
            end
            ST_CONV:
            begin
                // add three to digits of five or more, then shift in the next bit
                for (int j = 0; j < NUM_DIGITS; j++)
                    bcd_next[j] = (bcd_reg[j] >= 4'd5) ? bcd_reg[j] + 4'd3 : bcd_reg[j];
                for (int j = NUM_DIGITS - 1; j > 0; j--)
                    bcd_next[j] = {bcd_next[j][2:0], bcd_next[j-1][3]};
                bcd_next[0] = {bcd_next[0][2:0], mag_reg[VALUE_W-1]};
                mag_next    = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 6'd1;
                idx_next    = 5'(SCALE_DIGITS - 1) - {1'b0, dec_reg};
                add_next    = 3'd5;
                if (cnt_reg == 6'd63 && dec_reg == 4'(SCALE_DIGITS))
                    idx_next = 5'(NUM_DIGITS - 1);
            end
            ST_ROUND:
            begin
                if (rsum >= 5'd10)
                begin
                    bcd_next[idx_reg] = 4'(rsum - 5'd10);
                    add_next          = 3'd1;
                    idx_next          = idx_reg + 5'd1;
                end
                else
                    bcd_next[idx_reg] = rsum[3:0];
                if (rsum < 5'd10 || idx_reg == 5'(NUM_DIGITS - 1))
                    idx_next = 5'(NUM_DIGITS - 1);
            end
            ST_SCAN:
            begin
                if (idx_reg == 5'(SCALE_DIGITS) || cur_digit != 4'd0)
                begin
                    cnt3_next  = left_mod3(idx_reg);
                    first_next = 1'b1;
                    comma_next = 1'b0;
                end
                else
                    idx_next = idx_reg - 5'd1;
            end
            ST_INT:
            begin
                if (push && !at_limit)
                begin
                    if (need_comma)
                        comma_next = 1'b1;
                    else
                    begin
                        comma_next = 1'b0;
                        first_next = 1'b0;
                        cnt3_next  = (cnt3_reg == 2'd0) ? 2'd2 : cnt3_reg - 2'd1;
                        idx_next   = idx_reg - 5'd1;
                    end
                end
            end
            ST_FRAC:
            begin
                if (push)
                    idx_next = idx_reg - 5'd1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
            sent_reg      <= 5'd0;
            limit_reg     <= 7'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            sent_reg      <= sent_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        idx_reg      <= idx_next;
        neg_reg      <= neg_next;
        dol_reg      <= dol_next;
        grp_reg      <= grp_next;
        dec_reg      <= dec_next;
        first_reg    <= first_next;
        comma_reg    <= comma_next;
        cnt3_reg     <= cnt3_next;
        add_reg      <= add_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
    end

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_CONV)
        else $error("accepted beat did not start conversion");

    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == CH_NUL)
        else $error("final beat is not NUL");

    a_sent_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE && state_reg != ST_CONV |-> {2'b00, sent_reg} <= limit_reg)
        else $error("sent more characters than room allows");

    a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && cnt_reg != 6'd63 |=> state_reg == ST_CONV)
        else $error("conversion left early");

endmodule
